>>> sv/dlog_pkg.sv
package dlog_pkg;

   localparam int VAL_W       = 24;
   localparam int PROD_W      = 2 * VAL_W;
   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int IDX_W       = ADDR_W + 1;
   localparam int SQ_BIT_W    = $clog2(IDX_W);
   localparam int DIV_CNT_W   = $clog2(PROD_W + 1);
   localparam int CSR_IDX_W   = 2;
   localparam int STATUS_W    = 2;

   localparam logic [CSR_IDX_W-1:0] REG_BASE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MODULUS = 2'd1;

   localparam logic [STATUS_W-1:0] ST_FOUND = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOINV = 2'd2;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_NOINV,
      OP_DIV_BASE,
      OP_TAKE_A,
      OP_DIV_EUC,
      OP_TAKE_Q,
      OP_MUL_QS,
      OP_MUL_TA,
      OP_MUL_GI,
      OP_MUL_CG,
      OP_DIV_PROD,
      OP_TAKE_S,
      OP_TAKE_T,
      OP_TAKE_G,
      OP_TAKE_CG,
      OP_SQ_INIT,
      OP_SQ_STEP,
      OP_SQ_FIN,
      OP_G_INIT,
      OP_DIV_TGT,
      OP_TAKE_C,
      OP_SCAN,
      OP_GIANT,
      OP_FOUND,
      OP_MISS
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic n_small;
      logic cfg_wr;
      logic div_done;
      logic r1_zero;
      logic r0_one;
      logic sq_last;
      logic cnt_lt_m;
      logic scan_hit;
      logic scan_end;
      logic last_giant;
   } stat_type;

endpackage

>>> sv/dlog_divmod.sv
module dlog_divmod (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [dlog_pkg::PROD_W-1:0] dividend,
   input  logic [dlog_pkg::VAL_W-1:0]  divisor,
   output logic                        done,
   output logic [dlog_pkg::PROD_W-1:0] quot,
   output logic [dlog_pkg::VAL_W-1:0]  rem
);

   logic [dlog_pkg::VAL_W-1:0]     rem_ff, rem_in;
   logic [dlog_pkg::PROD_W-1:0]    dvd_ff, dvd_in;
   logic [dlog_pkg::VAL_W-1:0]     dsr_ff, dsr_in;
   logic [dlog_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           run_ff, run_in;
   logic                           done_ff, done_in;
   logic [dlog_pkg::VAL_W:0]       shifted;
   logic                           ge;

   // restoring division, one quotient bit a cycle
   always_comb begin
      shifted = {rem_ff, dvd_ff[dlog_pkg::PROD_W-1]};
      ge      = shifted >= {1'b0, dsr_ff};
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         dvd_in = dividend;
         dsr_in = divisor;
         cnt_in = dlog_pkg::DIV_CNT_W'(dlog_pkg::PROD_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? dlog_pkg::VAL_W'(shifted - {1'b0, dsr_ff})
                     : shifted[dlog_pkg::VAL_W-1:0];
         dvd_in = {dvd_ff[dlog_pkg::PROD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == dlog_pkg::DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = dvd_ff;
   assign rem  = rem_ff;

endmodule

>>> sv/dlog_datapath.sv
module dlog_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  dlog_pkg::cmd_type                cmd,
   output dlog_pkg::stat_type               stat,
   input  logic [dlog_pkg::VAL_W-1:0]       target,
   input  logic                             csr_we,
   input  logic [dlog_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dlog_pkg::VAL_W-1:0]       csr_wdata,
   output logic                             rsp_valid,
   output logic [dlog_pkg::VAL_W-1:0]       rsp_exponent,
   output logic [dlog_pkg::STATUS_W-1:0]    rsp_status
);

   localparam int VW = dlog_pkg::VAL_W;
   localparam int IW = dlog_pkg::IDX_W;
   localparam int AW = dlog_pkg::ADDR_W;

   logic [VW-1:0] base_ff, mod_ff;
   logic [VW-1:0] a_ff, c_ff, r0_ff, r1_ff, s0_ff, s1_ff, q_ff, tv_ff, g_ff;
   logic [VW-1:0] expb_ff, exp_ff;
   logic [dlog_pkg::STATUS_W-1:0] status_ff;
   logic          valid_ff;
   logic [dlog_pkg::PROD_W-1:0] prod_ff;
   logic [IW-1:0] m_ff, cnt_ff, i_ff, ja_ff, jd_ff, sq_r_ff;
   logic [dlog_pkg::SQ_BIT_W-1:0] sq_bit_ff;
   logic          vld_ff;
   logic [VW-1:0] rdata_ff;
   logic [VW-1:0] baby_mem [dlog_pkg::TABLE_DEPTH];

   logic                        div_start, div_done;
   logic [dlog_pkg::PROD_W-1:0] div_dvd, div_quot;
   logic [VW-1:0]               div_dsr, div_rem;
   logic [VW-1:0]               mul_x, mul_y, s2;
   logic [IW-1:0]               sq_t;
   logic [2*IW-1:0]             sq_tsq, sq_rsq;
   logic                        mem_we;
   logic [AW-1:0]               mem_waddr;
   logic [VW-1:0]               mem_wdata;
   logic                        issue;

   always_comb begin
      div_start = 1'b0;
      div_dvd   = {{VW{1'b0}}, base_ff};
      div_dsr   = mod_ff;
      unique case (cmd.op)
         dlog_pkg::OP_DIV_BASE: div_start = 1'b1;
         dlog_pkg::OP_DIV_EUC: begin
            div_start = 1'b1;
            div_dvd   = {{VW{1'b0}}, r0_ff};
            div_dsr   = r1_ff;
         end
         dlog_pkg::OP_DIV_TGT: begin
            div_start = 1'b1;
            div_dvd   = {{VW{1'b0}}, c_ff};
         end
         dlog_pkg::OP_DIV_PROD: begin
            div_start = 1'b1;
            div_dvd   = prod_ff;
         end
         default: div_start = 1'b0;
      endcase
   end

   dlog_divmod u_divmod (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   always_comb begin
      unique case (cmd.op)
         dlog_pkg::OP_MUL_QS: begin mul_x = q_ff;  mul_y = s1_ff; end
         dlog_pkg::OP_MUL_TA: begin mul_x = tv_ff; mul_y = a_ff;  end
         dlog_pkg::OP_MUL_GI: begin mul_x = g_ff;  mul_y = s0_ff; end
         default:             begin mul_x = c_ff;  mul_y = g_ff;  end
      endcase
   end

   // s0 - rem mod n, both below n
   assign s2 = (s0_ff >= div_rem) ? s0_ff - div_rem : s0_ff + (mod_ff - div_rem);

   assign sq_t   = sq_r_ff | (IW'(1) << sq_bit_ff);
   assign sq_tsq = sq_t * sq_t;
   assign sq_rsq = sq_r_ff * sq_r_ff;
   assign issue  = ja_ff < m_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= VW'(1);
         mod_ff   <= VW'(2);
         valid_ff <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         if (csr_we && csr_index == dlog_pkg::REG_BASE) base_ff <= csr_wdata;
         if (csr_we && csr_index == dlog_pkg::REG_MODULUS) mod_ff <= csr_wdata;
         valid_ff <= cmd.op == dlog_pkg::OP_FOUND || cmd.op == dlog_pkg::OP_MISS ||
                     cmd.op == dlog_pkg::OP_NOINV;
         vld_ff   <= cmd.op == dlog_pkg::OP_SCAN && issue;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         dlog_pkg::OP_LATCH:   c_ff <= target;
         dlog_pkg::OP_NOINV: begin
            exp_ff    <= '0;
            status_ff <= dlog_pkg::ST_NOINV;
         end
         dlog_pkg::OP_TAKE_A: begin
            a_ff  <= div_rem;
            r0_ff <= mod_ff;
            r1_ff <= div_rem;
            s0_ff <= '0;
            s1_ff <= VW'(1);
         end
         dlog_pkg::OP_TAKE_Q: begin
            q_ff  <= div_quot[VW-1:0];
            r0_ff <= r1_ff;
            r1_ff <= div_rem;
         end
         dlog_pkg::OP_MUL_QS, dlog_pkg::OP_MUL_TA, dlog_pkg::OP_MUL_GI,
         dlog_pkg::OP_MUL_CG:  prod_ff <= mul_x * mul_y;
         dlog_pkg::OP_TAKE_S: begin
            s0_ff <= s1_ff;
            s1_ff <= s2;
         end
         dlog_pkg::OP_TAKE_T: begin
            tv_ff  <= div_rem;
            cnt_ff <= cnt_ff + 1'b1;
         end
         dlog_pkg::OP_TAKE_G: begin
            g_ff   <= div_rem;
            cnt_ff <= cnt_ff + 1'b1;
         end
         dlog_pkg::OP_TAKE_CG: begin
            c_ff  <= div_rem;
            ja_ff <= '0;
         end
         dlog_pkg::OP_SQ_INIT: begin
            sq_r_ff   <= '0;
            sq_bit_ff <= dlog_pkg::SQ_BIT_W'(IW - 1);
         end
         dlog_pkg::OP_SQ_STEP: begin
            if (sq_tsq <= {{(2*IW-VW){1'b0}}, mod_ff}) sq_r_ff <= sq_t;
            sq_bit_ff <= sq_bit_ff - 1'b1;
         end
         dlog_pkg::OP_SQ_FIN: begin
            // ceiling: bump when the floor root falls short
            m_ff   <= (sq_rsq < {{(2*IW-VW){1'b0}}, mod_ff}) ? sq_r_ff + 1'b1 : sq_r_ff;
            tv_ff  <= VW'(1);
            cnt_ff <= IW'(1);
         end
         dlog_pkg::OP_G_INIT: begin
            g_ff   <= VW'(1);
            cnt_ff <= '0;
         end
         dlog_pkg::OP_TAKE_C: begin
            c_ff    <= div_rem;
            ja_ff   <= '0;
            i_ff    <= '0;
            expb_ff <= '0;
         end
         dlog_pkg::OP_SCAN: begin
            jd_ff <= ja_ff;
            if (issue) ja_ff <= ja_ff + 1'b1;
         end
         dlog_pkg::OP_GIANT: begin
            i_ff    <= i_ff + 1'b1;
            expb_ff <= expb_ff + VW'(m_ff);
         end
         dlog_pkg::OP_FOUND: begin
            exp_ff    <= expb_ff + VW'(jd_ff);
            status_ff <= dlog_pkg::ST_FOUND;
         end
         dlog_pkg::OP_MISS: begin
            exp_ff    <= '0;
            status_ff <= dlog_pkg::ST_MISS;
         end
         default: ;
      endcase
   end

   // baby-step table
   assign mem_we    = cmd.op == dlog_pkg::OP_TAKE_T || cmd.op == dlog_pkg::OP_SQ_FIN;
   assign mem_waddr = (cmd.op == dlog_pkg::OP_SQ_FIN) ? '0 : cnt_ff[AW-1:0];
   assign mem_wdata = (cmd.op == dlog_pkg::OP_SQ_FIN) ? VW'(1) : div_rem;

   always_ff @(posedge clock) begin
      if (mem_we) baby_mem[mem_waddr] <= mem_wdata;
      rdata_ff <= baby_mem[ja_ff[AW-1:0]];
   end

   always_comb begin
      stat.n_small    = mod_ff < VW'(2);
      stat.cfg_wr     = csr_we && (csr_index == dlog_pkg::REG_BASE ||
                                   csr_index == dlog_pkg::REG_MODULUS);
      stat.div_done   = div_done;
      stat.r1_zero    = r1_ff == '0;
      stat.r0_one     = r0_ff == VW'(1);
      stat.sq_last    = sq_bit_ff == '0;
      stat.cnt_lt_m   = cnt_ff < m_ff;
      stat.scan_hit   = vld_ff && rdata_ff == c_ff;
      stat.scan_end   = vld_ff && jd_ff == m_ff - 1'b1;
      stat.last_giant = i_ff == m_ff - 1'b1;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_exponent = exp_ff;
   assign rsp_status   = status_ff;

endmodule

>>> sv/dlog_ctrl.sv
module dlog_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  dlog_pkg::stat_type stat,
   output dlog_pkg::cmd_type  cmd
);

   typedef enum logic [16:0] {
      S_IDLE     = 17'h00001,
      S_RED_GO   = 17'h00002,
      S_RED_WAIT = 17'h00004,
      S_EUC_CHK  = 17'h00008,
      S_EUC_GO   = 17'h00010,
      S_EUC_WAIT = 17'h00020,
      S_SQ_STEP  = 17'h00040,
      S_SQ_FIN   = 17'h00080,
      S_TBL_CHK  = 17'h00100,
      S_GF_CHK   = 17'h00200,
      S_TGT_GO   = 17'h00400,
      S_TGT_WAIT = 17'h00800,
      S_SCAN     = 17'h01000,
      S_MUL      = 17'h02000,
      S_MOD_GO   = 17'h04000,
      S_MOD_WAIT = 17'h08000,
      S_SPARE    = 17'h10000
   } state_type;

   typedef enum logic [1:0] {K_QS, K_TA, K_GI, K_CG} kind_type;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      ready_in = ready_ff;
      cmd.op   = dlog_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (stat.n_small) cmd.op = dlog_pkg::OP_NOINV;
               else begin
                  cmd.op   = dlog_pkg::OP_LATCH;
                  state_in = S_RED_GO;
               end
            end
         end
         S_RED_GO: begin
            cmd.op   = dlog_pkg::OP_DIV_BASE;
            state_in = S_RED_WAIT;
         end
         S_RED_WAIT: begin
            if (stat.div_done) begin
               cmd.op   = dlog_pkg::OP_TAKE_A;
               state_in = S_EUC_CHK;
            end
         end
         S_EUC_CHK: begin
            if (!stat.r1_zero) state_in = S_EUC_GO;
            else if (!stat.r0_one) begin
               cmd.op   = dlog_pkg::OP_NOINV;
               ready_in = 1'b0;
               state_in = S_IDLE;
            end else if (ready_ff) state_in = S_TGT_GO;
            else begin
               cmd.op   = dlog_pkg::OP_SQ_INIT;
               state_in = S_SQ_STEP;
            end
         end
         S_EUC_GO: begin
            cmd.op   = dlog_pkg::OP_DIV_EUC;
            state_in = S_EUC_WAIT;
         end
         S_EUC_WAIT: begin
            if (stat.div_done) begin
               cmd.op   = dlog_pkg::OP_TAKE_Q;
               kind_in  = K_QS;
               state_in = S_MUL;
            end
         end
         S_SQ_STEP: begin
            cmd.op = dlog_pkg::OP_SQ_STEP;
            if (stat.sq_last) state_in = S_SQ_FIN;
         end
         S_SQ_FIN: begin
            cmd.op   = dlog_pkg::OP_SQ_FIN;
            state_in = S_TBL_CHK;
         end
         S_TBL_CHK: begin
            if (stat.cnt_lt_m) begin
               kind_in  = K_TA;
               state_in = S_MUL;
            end else begin
               cmd.op   = dlog_pkg::OP_G_INIT;
               state_in = S_GF_CHK;
            end
         end
         S_GF_CHK: begin
            if (stat.cnt_lt_m) begin
               kind_in  = K_GI;
               state_in = S_MUL;
            end else begin
               ready_in = 1'b1;
               state_in = S_TGT_GO;
            end
         end
         S_TGT_GO: begin
            cmd.op   = dlog_pkg::OP_DIV_TGT;
            state_in = S_TGT_WAIT;
         end
         S_TGT_WAIT: begin
            if (stat.div_done) begin
               cmd.op   = dlog_pkg::OP_TAKE_C;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.scan_hit) begin
               cmd.op   = dlog_pkg::OP_FOUND;
               state_in = S_IDLE;
            end else if (stat.scan_end) begin
               if (stat.last_giant) begin
                  cmd.op   = dlog_pkg::OP_MISS;
                  state_in = S_IDLE;
               end else begin
                  cmd.op   = dlog_pkg::OP_GIANT;
                  kind_in  = K_CG;
                  state_in = S_MUL;
               end
            end else cmd.op = dlog_pkg::OP_SCAN;
         end
         S_MUL: begin
            unique case (kind_ff)
               K_QS:    cmd.op = dlog_pkg::OP_MUL_QS;
               K_TA:    cmd.op = dlog_pkg::OP_MUL_TA;
               K_GI:    cmd.op = dlog_pkg::OP_MUL_GI;
               default: cmd.op = dlog_pkg::OP_MUL_CG;
            endcase
            state_in = S_MOD_GO;
         end
         S_MOD_GO: begin
            cmd.op   = dlog_pkg::OP_DIV_PROD;
            state_in = S_MOD_WAIT;
         end
         S_MOD_WAIT: begin
            if (stat.div_done) begin
               unique case (kind_ff)
                  K_QS: begin
                     cmd.op   = dlog_pkg::OP_TAKE_S;
                     state_in = S_EUC_CHK;
                  end
                  K_TA: begin
                     cmd.op   = dlog_pkg::OP_TAKE_T;
                     state_in = S_TBL_CHK;
                  end
                  K_GI: begin
                     cmd.op   = dlog_pkg::OP_TAKE_G;
                     state_in = S_GF_CHK;
                  end
                  default: begin
                     cmd.op   = dlog_pkg::OP_TAKE_CG;
                     state_in = S_SCAN;
                  end
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
      // table is rebuilt after any write to the base or modulus register
      if (stat.cfg_wr) ready_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule

>>> sv/discrete_log_bsgs.sv
// Discrete logarithm by baby-step giant-step. A target is taken when start is high and busy
// is low; one result beat follows on rsp_valid for a single cycle and cannot be held off.
// The result comes in the cycle after acceptance when the modulus is below two. Otherwise
// each item runs an extended Euclid inverse check (a shared divider sets the pace), then, on
// the first item after reset or a base or modulus write, builds the table and giant factor
// (m entries, m = ceil(sqrt(modulus))), then scans: one table read per cycle, up to m reads
// per giant step followed by the next giant multiply, for up to m giant steps.
module discrete_log_bsgs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [dlog_pkg::VAL_W-1:0]           req_target,
   output logic                                 rsp_valid,
   output logic [dlog_pkg::VAL_W-1:0]           rsp_exponent,
   output logic [dlog_pkg::STATUS_W-1:0]        rsp_status,
   input  logic                                 csr_we,
   input  logic [dlog_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dlog_pkg::VAL_W-1:0]           csr_wdata
);

   dlog_pkg::cmd_type  cmd;
   dlog_pkg::stat_type stat;

   dlog_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   dlog_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .target       (req_target),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_valid),
      .rsp_exponent (rsp_exponent),
      .rsp_status   (rsp_status)
   );

endmodule

>>> tb/sv/discrete_log_bsgs_test.sv
module discrete_log_bsgs_test;

   localparam longint CYCLE_LIMIT = 40_000_000;

   typedef struct {
      logic [dlog_pkg::VAL_W-1:0]    exponent;
      logic [dlog_pkg::STATUS_W-1:0] status;
   } dlog_answer_type;

   class dlog_scoreboard;
      dlog_answer_type pending_answers[$];
      int              errors = 0;

      function void note_target(dlog_answer_type ans);
         pending_answers.push_back(ans);
      endfunction

      function void check_answer(logic [dlog_pkg::VAL_W-1:0] exponent,
                                 logic [dlog_pkg::STATUS_W-1:0] status);
         dlog_answer_type want;
         if (pending_answers.size() == 0) begin
            $error("result beat with nothing pending: exponent %0d status %0d",
                   exponent, status);
            errors++;
            return;
         end
         want = pending_answers.pop_front();
         if (exponent !== want.exponent) begin
            $error("exponent: expected %0d, actual %0d", want.exponent, exponent);
            errors++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
         end
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic [dlog_pkg::VAL_W-1:0]        req_target;
   logic                              rsp_valid;
   logic [dlog_pkg::VAL_W-1:0]        rsp_exponent;
   logic [dlog_pkg::STATUS_W-1:0]     rsp_status;
   logic                              csr_we;
   logic [dlog_pkg::CSR_IDX_W-1:0]    csr_index;
   logic [dlog_pkg::VAL_W-1:0]        csr_wdata;

   dlog_scoreboard             sb = new();
   logic [dlog_pkg::VAL_W-1:0] cfg_base = dlog_pkg::VAL_W'(1);
   logic [dlog_pkg::VAL_W-1:0] cfg_modulus = dlog_pkg::VAL_W'(2);
   int                         sender_idle_pct = 0;
   longint                     cycle_count = 0;
   int                         sent_pct_list[3] = '{37, 82, 0};

   discrete_log_bsgs dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_target(req_target),
      .rsp_valid(rsp_valid), .rsp_exponent(rsp_exponent), .rsp_status(rsp_status),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("discrete_log_bsgs_test: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_answer(rsp_exponent, rsp_status);
   end

   function automatic longint power_mod(longint a, longint e, longint n);
      longint r;
      r = 1 % n;
      a = a % n;
      while (e > 0) begin
         if (e & 1)
            r = (r * a) % n;
         a = (a * a) % n;
         e = e >> 1;
      end
      return r;
   endfunction

   // smallest giant step first, then smallest baby index within it
   function automatic dlog_answer_type find_exponent(logic [dlog_pkg::VAL_W-1:0] tgt);
      dlog_answer_type ans;
      longint n, a, c, m, g, q, t, r0, r1, s0, s1;
      longint babies[$];
      n = cfg_modulus;
      ans.exponent = '0;
      ans.status = dlog_pkg::ST_NOINV;
      if (n < 2)
         return ans;
      a = cfg_base % n;
      r0 = n; r1 = a; s0 = 0; s1 = 1;
      while (r1 != 0) begin
         q = r0 / r1;
         t = r0 - q * r1; r0 = r1; r1 = t;
         t = s0 - q * s1; s0 = s1; s1 = t;
      end
      if (r0 != 1)
         return ans;
      s0 = ((s0 % n) + n) % n;
      m = 0;
      while (m * m < n)
         m++;
      if (m > dlog_pkg::TABLE_DEPTH)
         m = dlog_pkg::TABLE_DEPTH;
      babies.push_back(1);
      for (longint j = 1; j < m; j++)
         babies.push_back((babies[j-1] * a) % n);
      g = power_mod(s0, m, n);
      c = tgt % n;
      for (longint i = 0; i < m; i++) begin
         for (longint j = 0; j < m; j++) begin
            if (babies[j] == c) begin
               ans.exponent = dlog_pkg::VAL_W'(i * m + j);
               ans.status = dlog_pkg::ST_FOUND;
               return ans;
            end
         end
         c = (c * g) % n;
      end
      ans.status = dlog_pkg::ST_MISS;
      return ans;
   endfunction

   task automatic send_target(input logic [dlog_pkg::VAL_W-1:0] tgt);
      req_target <= tgt;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_target(find_exponent(tgt));
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [dlog_pkg::CSR_IDX_W-1:0] idx,
                            input logic [dlog_pkg::VAL_W-1:0] val);
      start <= 1'b0;
      while (sb.pending_answers.size() != 0 || busy)
         @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == dlog_pkg::REG_BASE)
         cfg_base = val;
      else if (idx == dlog_pkg::REG_MODULUS)
         cfg_modulus = val;
      csr_we <= 1'b0;
   endtask

   task automatic set_config(input logic [dlog_pkg::VAL_W-1:0] b,
                             input logic [dlog_pkg::VAL_W-1:0] n);
      write_reg(dlog_pkg::REG_BASE, b);
      write_reg(dlog_pkg::REG_MODULUS, n);
   endtask

   // one configuration, then a burst of targets, mostly reachable powers of the base
   task automatic random_block(inout int sent);
      logic [dlog_pkg::VAL_W-1:0] n;
      int                         burst;
      case ($urandom_range(0, 9))
         0:       n = dlog_pkg::VAL_W'($urandom_range(0, 1));
         1:       n = dlog_pkg::VAL_W'($urandom_range(2000, 5000));
         default: n = dlog_pkg::VAL_W'($urandom_range(2, 1200));
      endcase
      if ($urandom_range(0, 7) == 0)
         write_reg(dlog_pkg::CSR_IDX_W'($urandom_range(2, 3)), dlog_pkg::VAL_W'($urandom));
      set_config(dlog_pkg::VAL_W'($urandom), n);
      burst = $urandom_range(3, 8);
      repeat (burst) begin
         if (n >= 2 && $urandom_range(99) < 70)
            send_target(dlog_pkg::VAL_W'(power_mod(cfg_base, $urandom_range(0, n - 1), n)));
         else
            send_target(dlog_pkg::VAL_W'($urandom));
         sent++;
      end
   endtask

   initial begin
      int sent;
      reset = 1'b1;
      start = 1'b0;
      req_target = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, small moduli, non-invertible bases, repeats in the table
      send_target(24'd0);
      send_target(24'd1);
      send_target(24'hFFFFFF);
      write_reg(dlog_pkg::REG_MODULUS, 24'd0);
      send_target(24'd5);
      write_reg(dlog_pkg::REG_MODULUS, 24'd1);
      send_target(24'hFFFFFF);
      write_reg(2'd2, 24'hFFFFFF);
      write_reg(2'd3, 24'hFFFFFF);
      set_config(24'd0, 24'd101);
      send_target(24'd1);
      set_config(24'hFFFFFF, 24'hFFFFFF);
      send_target(24'hFFFFFF);
      set_config(24'd2, 24'd101);
      send_target(24'd1);
      send_target(24'd2);
      send_target(24'd0);
      send_target(24'd104);
      send_target(24'hFFFFFF);
      set_config(24'd10, 24'd11);
      send_target(24'd1);
      send_target(24'd10);
      send_target(24'd5);
      set_config(24'd17, 24'd65521);
      send_target(dlog_pkg::VAL_W'(power_mod(17, 5, 65521)));
      send_target(dlog_pkg::VAL_W'(power_mod(17, 300, 65521)));

      foreach (sent_pct_list[p]) begin
         sender_idle_pct = sent_pct_list[p];
         sent = 0;
         while (sent < 27)
            random_block(sent);
      end
      start <= 1'b0;

      while (sb.pending_answers.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("discrete_log_bsgs_test: PASS");
      else
         $display("discrete_log_bsgs_test: FAIL");
      $finish;
   end

endmodule
